// File: hdl/grouped_free_block_allocator_defines.svh
`ifndef GROUPED_FREE_BLOCK_ALLOCATOR_DEFINES_SVH
`define GROUPED_FREE_BLOCK_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define GFBA_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GFBA_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/gfba_pkg.sv
`default_nettype none

package gfba_pkg;

  localparam int GROUP_SIZE  = 64;
  localparam int NUM_BLOCKS  = 1024;
  localparam int BLK_W       = 10;
  localparam int SPILL_GROUPS = 1 << BLK_W;
  localparam int SP_W        = $clog2(GROUP_SIZE);
  localparam int IDX_W       = $clog2(GROUP_SIZE + 1);
  localparam int CNT_W       = $clog2(NUM_BLOCKS + 1);
  localparam int SPILL_DEPTH = SPILL_GROUPS * GROUP_SIZE;
  localparam int SPILL_AW    = $clog2(SPILL_DEPTH);

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [BLK_W-1:0] freed_block;
  } req_t;

  typedef struct packed {
    logic [BLK_W-1:0] granted_block;
    logic             full_res;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_ALLOC_WAIT,
    ST_SPILL,
    ST_RELOAD
  } state_t;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_RD,
    RES_GBLK
  } res_src_t;

  typedef struct packed {
    logic     load_in;
    logic     rd_top;
    logic     idx_clr;
    logic     idx_inc;
    logic     spill_wr;
    logic     reload_wr;
    logic     push_dec;
    logic     push_top;
    logic     pop_inc;
    logic     pop_reload;
    logic     grant_latch;
    logic     res_fire;
    logic     res_full;
    res_src_t res_src;
  } cmd_t;

  typedef struct packed {
    logic kind_free;
    logic cnt_zero;
    logic sp_zero;
    logic sp_top;
    logic idx_first;
    logic idx_last;
  } status_t;

  function automatic logic [SPILL_AW-1:0] spill_addr(input logic [BLK_W-1:0] blk,
                                                     input logic [SP_W-1:0]  off);
    spill_addr = SPILL_AW'(blk) * SPILL_AW'(GROUP_SIZE) + SPILL_AW'(off);
  endfunction

endpackage

`default_nettype wire

// File: hdl/gfba_ctrl.sv
`default_nettype none
`include "grouped_free_block_allocator_defines.svh"

module gfba_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              start,
  output logic             busy,
  input  gfba_pkg::status_t st,
  output gfba_pkg::cmd_t   cmd
);
  import gfba_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.res_src = RES_ZERO;
    busy       = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load_in = 1'b1;
          state_next  = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!st.kind_free) begin
          if (st.cnt_zero) begin
            cmd.res_fire = 1'b1;
            cmd.res_full = 1'b1;
            state_next   = ST_IDLE;
          end else begin
            cmd.rd_top = 1'b1;
            state_next = ST_ALLOC_WAIT;
          end
        end else if (!st.sp_zero) begin
          cmd.push_dec = 1'b1;
          cmd.res_fire = 1'b1;
          state_next   = ST_IDLE;
        end else begin
          cmd.idx_clr = 1'b1;
          state_next  = ST_SPILL;
        end
      end
      ST_ALLOC_WAIT: begin
        if (st.sp_top) begin
          cmd.grant_latch = 1'b1;
          cmd.idx_clr     = 1'b1;
          state_next      = ST_RELOAD;
        end else begin
          cmd.pop_inc  = 1'b1;
          cmd.res_fire = 1'b1;
          cmd.res_src  = RES_RD;
          state_next   = ST_IDLE;
        end
      end
      ST_SPILL: begin
        cmd.spill_wr = !st.idx_first;
        if (st.idx_last) begin
          cmd.push_top = 1'b1;
          cmd.res_fire = 1'b1;
          state_next   = ST_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      ST_RELOAD: begin
        cmd.reload_wr = !st.idx_first;
        if (st.idx_last) begin
          cmd.pop_reload = 1'b1;
          cmd.res_fire   = 1'b1;
          cmd.res_src    = RES_GBLK;
          state_next     = ST_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `GFBA_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy, "accept did not raise busy")
  `GFBA_ASSERT_IMP(a_one_result, clk, rst, cmd.res_fire, state_next == ST_IDLE,
                   "result issued while work remains")
  `GFBA_ASSERT_NXT(a_load_decide, clk, rst, cmd.load_in, state == ST_DECIDE,
                   "load did not enter decide")

endmodule

`default_nettype wire

// File: hdl/gfba_dpath.sv
`default_nettype none
`include "grouped_free_block_allocator_defines.svh"

module gfba_dpath (
  input  wire               clk,
  input  wire               rst,
  input  gfba_pkg::req_t    request,
  input  gfba_pkg::cmd_t    cmd,
  output gfba_pkg::status_t st,
  output gfba_pkg::res_t    result,
  output logic              done
);
  import gfba_pkg::*;

  logic             kind_q;
  logic [BLK_W-1:0] blk_q;
  logic [BLK_W-1:0] gblk;
  logic [SP_W-1:0]  sp;
  logic [CNT_W-1:0] cnt;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_m1;

  logic [BLK_W-1:0] stk_mem [GROUP_SIZE];
  logic [GROUP_SIZE-1:0] stk_vld;
  logic [BLK_W-1:0] stk_q;
  logic             stk_vld_q;
  logic [BLK_W-1:0] stk_rd;
  logic [SP_W-1:0]  stk_ra;
  logic [SP_W-1:0]  stk_wa;
  logic [BLK_W-1:0] stk_wd;
  logic             stk_we;

  logic [BLK_W-1:0]    spill_mem [SPILL_DEPTH];
  logic [BLK_W-1:0]    spill_q;
  logic [SPILL_AW-1:0] spill_ra;
  logic [SPILL_AW-1:0] spill_wa;

  logic [BLK_W-1:0] granted_q;
  logic             full_q;
  logic [CNT_W-1:0] cnt_inc;

  assign idx_m1  = idx - IDX_W'(1);
  assign stk_rd  = stk_vld_q ? stk_q : '0;
  assign stk_ra  = cmd.rd_top ? sp : idx[SP_W-1:0];
  assign cnt_inc = (cnt == CNT_W'(NUM_BLOCKS)) ? cnt : cnt + CNT_W'(1);

  always_comb begin
    stk_we = 1'b0;
    stk_wa = idx_m1[SP_W-1:0];
    stk_wd = spill_q;
    if (cmd.push_dec) begin
      stk_we = 1'b1;
      stk_wa = sp - SP_W'(1);
      stk_wd = blk_q;
    end else if (cmd.push_top) begin
      stk_we = 1'b1;
      stk_wa = SP_W'(GROUP_SIZE - 1);
      stk_wd = blk_q;
    end else if (cmd.reload_wr) begin
      stk_we = 1'b1;
    end
  end

  assign spill_ra = spill_addr(gblk, idx[SP_W-1:0]);
  assign spill_wa = spill_addr(blk_q, idx_m1[SP_W-1:0]);

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    stk_q     <= stk_mem[stk_ra];
    stk_vld_q <= stk_vld[stk_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stk_vld <= '0;
    end else if (stk_we) begin
      stk_vld[stk_wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.spill_wr) begin
      spill_mem[spill_wa] <= stk_rd;
    end
    spill_q <= spill_mem[spill_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_q <= request.kind;
      blk_q  <= request.freed_block;
    end
    if (cmd.grant_latch) begin
      gblk <= stk_rd;
    end
    case (cmd.res_src)
      RES_RD:   granted_q <= stk_rd;
      RES_GBLK: granted_q <= gblk;
      default:  granted_q <= '0;
    endcase
    full_q <= cmd.res_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp   <= '0;
      cnt  <= '0;
      idx  <= '0;
      done <= 1'b0;
    end else begin
      done <= cmd.res_fire;
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + IDX_W'(1);
      end
      if (cmd.push_dec) begin
        sp  <= sp - SP_W'(1);
        cnt <= cnt_inc;
      end else if (cmd.push_top) begin
        sp  <= SP_W'(GROUP_SIZE - 1);
        cnt <= cnt_inc;
      end else if (cmd.pop_inc) begin
        sp  <= sp + SP_W'(1);
        cnt <= cnt - CNT_W'(1);
      end else if (cmd.pop_reload) begin
        sp  <= '0;
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  always_comb begin
    st.kind_free = (kind_q == KIND_FREE);
    st.cnt_zero  = (cnt == '0);
    st.sp_zero   = (sp == '0);
    st.sp_top    = (sp == SP_W'(GROUP_SIZE - 1));
    st.idx_first = (idx == '0);
    st.idx_last  = (idx == IDX_W'(GROUP_SIZE));
  end

  assign result.granted_block = granted_q;
  assign result.full_res      = full_q;

  `GFBA_ASSERT_IMP(a_cnt_cap, clk, rst, 1'b1, cnt <= CNT_W'(NUM_BLOCKS), "free count overflow")
  `GFBA_ASSERT_IMP(a_pop_nonempty, clk, rst, cmd.pop_inc || cmd.pop_reload, cnt != '0,
                   "allocation with empty pool")
  `GFBA_ASSERT_NXT(a_full_zero, clk, rst, cmd.res_fire && cmd.res_full,
                   done && granted_q == '0, "full result carries a block")

endmodule

`default_nettype wire

// File: hdl/grouped_free_block_allocator.sv
`default_nettype none

// Grouped free-block allocator. One transaction is accepted when start is high
// and busy is low; each transaction gives exactly one result, shown on result
// for a single cycle with done high. The receiver cannot stall, so the result
// must be taken in that cycle. A free with the stack pointer at 0 spills the
// group and an allocation taking the last entry reloads it; in both cases the
// group is copied one entry per cycle between the stack and the spill memory.

module grouped_free_block_allocator (
  input  wire             clk,
  input  wire             rst,
  input  wire             start,
  output logic            busy,
  input  gfba_pkg::req_t  request,
  output gfba_pkg::res_t  result,
  output logic            done
);
  import gfba_pkg::*;

  cmd_t    cmd;
  status_t st;

  gfba_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .st    (st),
    .cmd   (cmd)
  );

  gfba_dpath u_dpath (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .st      (st),
    .result  (result),
    .done    (done)
  );

endmodule

`default_nettype wire
